[hw/rtl/vkq_pkg.sv]
// vkq_pkg: widths, reset values, register indexes and constants of the
// volume knob qualifier. No dependencies; used by every other file.
`default_nettype none

package vkq_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 8;
    localparam int OFFSET_W   = 8;
    localparam int STEP_W     = 8;
    localparam int THR_W      = SAMPLE_W + 1;     // enter level + release offset
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // divider geometry
    localparam int DIVIDEND_W = THR_W;            // magnitude of either segment offset
    localparam int DIVISOR_W  = STEP_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    // smoothing
    localparam int AVG_W      = 12;
    localparam int POS_W      = 6;                // -31..31

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_ENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_RELEASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BREAK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_STEP     = 3'd4;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_MUTE_ENTER    = 12'd30;
    localparam logic [OFFSET_W-1:0] RST_MUTE_RELEASE  = 8'd8;
    localparam logic [SAMPLE_W-1:0] RST_SEGMENT_BREAK = 12'd317;
    localparam logic [STEP_W-1:0]   RST_LOW_STEP      = 8'd9;
    localparam logic [STEP_W-1:0]   RST_HIGH_STEP     = 8'd54;

    // constants
    localparam logic signed [LEVEL_W-1:0] MUTE_CODE = -8'sd99;
    localparam logic signed [AVG_W-1:0]   MUTE_AVG  = -12'sd1584;   // MUTE_CODE * 16
    localparam logic signed [POS_W-1:0]   POS_MAX   = 6'sd31;
    localparam logic signed [POS_W-1:0]   POS_MIN   = -6'sd31;
    localparam int                        LEAK_BIAS  = 8;
    localparam int                        LEAK_SHIFT = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mute_enter_level;
        logic [OFFSET_W-1:0] mute_release_offset;
        logic [SAMPLE_W-1:0] segment_break_point;
        logic [STEP_W-1:0]   low_segment_step;
        logic [STEP_W-1:0]   high_segment_step;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/vkq_if.sv]
// Handshake channels of the volume knob qualifier: sample in, result out,
// register write. Depends on vkq_pkg for payload widths.
`default_nettype none

interface vkq_sample_if;
    logic                          valid;
    logic                          ready;
    logic [vkq_pkg::SAMPLE_W-1:0]  pot_sample;

    modport source (output valid, output pot_sample, input ready);
    modport sink   (input valid, input pot_sample, output ready);
endinterface

interface vkq_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [vkq_pkg::LEVEL_W-1:0]  volume_level;
    logic                                muted;

    modport source (output valid, output volume_level, output muted, input ready);
    modport sink   (input valid, input volume_level, input muted, output ready);
endinterface

interface vkq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vkq_pkg::CFG_IDX_W-1:0]   index;
    logic [vkq_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/vkq_cfg_regs.sv]
// vkq_cfg_regs: the five configuration registers, written over the cfg
// channel. Depends on vkq_pkg and vkq_cfg_if.
`default_nettype none

module vkq_cfg_regs (
    input  wire logic     clk,
    input  wire logic     rst_n,
    vkq_cfg_if.sink       cfg,
    output vkq_pkg::cfg_t regs
);

    vkq_pkg::cfg_t regs_reg;
    vkq_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                vkq_pkg::REG_MUTE_ENTER:
                    regs_next.mute_enter_level = cfg.data[vkq_pkg::SAMPLE_W-1:0];
                vkq_pkg::REG_MUTE_RELEASE:
                    regs_next.mute_release_offset = cfg.data[vkq_pkg::OFFSET_W-1:0];
                vkq_pkg::REG_SEGMENT_BREAK:
                    regs_next.segment_break_point = cfg.data[vkq_pkg::SAMPLE_W-1:0];
                vkq_pkg::REG_LOW_STEP:
                    regs_next.low_segment_step = cfg.data[vkq_pkg::STEP_W-1:0];
                vkq_pkg::REG_HIGH_STEP:
                    regs_next.high_segment_step = cfg.data[vkq_pkg::STEP_W-1:0];
                default:
                    regs_next = regs_reg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.mute_enter_level    <= vkq_pkg::RST_MUTE_ENTER;
            regs_reg.mute_release_offset <= vkq_pkg::RST_MUTE_RELEASE;
            regs_reg.segment_break_point <= vkq_pkg::RST_SEGMENT_BREAK;
            regs_reg.low_segment_step    <= vkq_pkg::RST_LOW_STEP;
            regs_reg.high_segment_step   <= vkq_pkg::RST_HIGH_STEP;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vkq_divider.sv]
// vkq_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on vkq_pkg for its widths.
`default_nettype none

module vkq_divider (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [vkq_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [vkq_pkg::DIVISOR_W-1:0]    divisor,
    output logic                                  done,
    output logic [vkq_pkg::DIVIDEND_W-1:0]        quotient
);

    logic [vkq_pkg::DIVIDEND_W-1:0] quo_reg;    // dividend shifts out, quotient in
    logic [vkq_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [vkq_pkg::DIVISOR_W-1:0]  div_reg;
    logic [vkq_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [vkq_pkg::DIVISOR_W:0]    trial;
    logic                           fits;
    logic [vkq_pkg::DIVISOR_W:0]    trial_sub;

    assign trial     = {rem_reg, quo_reg[vkq_pkg::DIVIDEND_W-1]};
    assign fits      = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= vkq_pkg::DIV_CNT_W'(vkq_pkg::DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[vkq_pkg::DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? trial_sub[vkq_pkg::DIVISOR_W-1:0]
                            : trial[vkq_pkg::DIVISOR_W-1:0];
        end
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

endmodule

`default_nettype wire

[hw/rtl/volume_knob_qualifier_unit.sv]
// volume_knob_qualifier_unit: top level of the volume knob qualifier.
// Depends on vkq_pkg, vkq_if, vkq_cfg_regs and vkq_divider.
//
// Use:
//  - sample: one 12-bit knob reading per transfer (valid/ready).
//  - result: volume_level (-31..31, or -99 when muted) and the muted flag,
//    one result per sample, held in an output register until transferred.
//  - cfg: register writes (index, data); always ready. Write only while
//    the block is idle.
// Flow:
//  - A non-muted sample runs through the shared divider, one quotient bit
//    a cycle, and then through the finishing state, which writes the
//    output register; the next sample is taken once the sequencer is back
//    in idle.
//  - A muted sample skips the divider and goes straight from the
//    transfer to the finishing state.
//  - The sequencer accepts the next sample while a result waits in the
//    output register; it only stalls in its finishing cycle if the
//    previous result has still not been transferred.
// Reset: registers return to their default values, mute is released and
//  the running average is zero; no result is pending.
`default_nettype none

module volume_knob_qualifier_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    vkq_sample_if.sink    sample,
    vkq_result_if.source  result,
    vkq_cfg_if.sink       cfg
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    vkq_pkg::cfg_t regs;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // per-sample context captured at the transfer
    logic mute_reg;
    logic low_reg;      // low segment selected
    logic neg_reg;      // low segment offset below the release threshold

    // persistent state
    logic                                latch_reg;
    logic signed [vkq_pkg::AVG_W-1:0]    avg_reg;

    // output register
    logic                                res_valid_reg;
    logic signed [vkq_pkg::LEVEL_W-1:0]  res_level_reg;
    logic                                res_muted_reg;

    vkq_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // ---------------------------------------------------------------
    // Sample setup: mute decision and divider operands
    // ---------------------------------------------------------------
    logic                                   accept;
    logic [vkq_pkg::THR_W-1:0]              hi_thr;
    logic                                   mute_now;
    logic                                   low_seg;
    logic signed [vkq_pkg::THR_W:0]         low_diff;
    logic [vkq_pkg::THR_W:0]                low_mag;
    logic [vkq_pkg::SAMPLE_W-1:0]           high_diff;
    logic [vkq_pkg::DIVIDEND_W-1:0]         dividend;
    logic [vkq_pkg::DIVISOR_W-1:0]          low_step;
    logic [vkq_pkg::DIVISOR_W-1:0]          high_step;
    logic [vkq_pkg::DIVISOR_W-1:0]          divisor;
    logic                                   div_start;
    logic                                   div_done;
    logic [vkq_pkg::DIVIDEND_W-1:0]         quotient;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;

    // release threshold, also the zero point of the low segment
    assign hi_thr = {1'b0, regs.mute_enter_level}
                  + {{(vkq_pkg::THR_W - vkq_pkg::OFFSET_W){1'b0}}, regs.mute_release_offset};

    assign mute_now = latch_reg ? ({1'b0, sample.pot_sample} < hi_thr)
                                : (sample.pot_sample < regs.mute_enter_level);

    assign low_seg   = sample.pot_sample < regs.segment_break_point;
    assign low_diff  = $signed({2'b00, sample.pot_sample}) - $signed({1'b0, hi_thr});
    assign low_mag   = low_diff[vkq_pkg::THR_W] ? (~low_diff + 1'b1) : low_diff;
    assign high_diff = sample.pot_sample - regs.segment_break_point;

    // a zero step acts as a step of one
    assign low_step  = (regs.low_segment_step == '0) ? vkq_pkg::DIVISOR_W'(1)
                                                     : regs.low_segment_step;
    assign high_step = (regs.high_segment_step == '0) ? vkq_pkg::DIVISOR_W'(1)
                                                      : regs.high_segment_step;

    assign dividend = low_seg ? low_mag[vkq_pkg::DIVIDEND_W-1:0]
                              : {1'b0, high_diff};
    assign divisor  = low_seg ? low_step : high_step;
    assign div_start = accept && !mute_now;

    vkq_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------------------------------------------------------
    // Finishing: position, clamp, leaky average
    // ---------------------------------------------------------------
    logic                                   out_free;
    logic                                   finish;
    logic signed [vkq_pkg::THR_W:0]         q_s;
    logic signed [vkq_pkg::THR_W:0]         raw;
    logic signed [vkq_pkg::THR_W+1:0]       pos;
    logic signed [vkq_pkg::POS_W-1:0]       v;
    logic                                   restart;
    logic signed [vkq_pkg::AVG_W:0]         avg_m8;
    logic signed [vkq_pkg::AVG_W:0]         leak;
    logic signed [vkq_pkg::AVG_W+1:0]       avg_sum;
    logic signed [vkq_pkg::AVG_W-1:0]       avg_smooth;
    logic signed [vkq_pkg::LEVEL_W-1:0]     avg_div16;
    logic signed [vkq_pkg::POS_W-1:0]       smooth_pos;
    logic signed [vkq_pkg::POS_W-1:0]       res_pos;
    logic signed [vkq_pkg::AVG_W-1:0]       avg_next;
    logic signed [vkq_pkg::LEVEL_W-1:0]     level_next;

    assign out_free = !res_valid_reg || result.ready;
    assign finish   = (state_reg == ST_DONE) && out_free;

    assign q_s = $signed({1'b0, quotient});
    assign raw = neg_reg ? -q_s : q_s;
    // low segment sits 31 below the high segment's origin
    assign pos = low_reg ? ($signed({raw[vkq_pkg::THR_W], raw}) - 15'sd31)
                         : $signed({1'b0, q_s});

    always_comb
    begin
        if (pos > vkq_pkg::POS_MAX)
            v = vkq_pkg::POS_MAX;
        else if (pos < vkq_pkg::POS_MIN)
            v = vkq_pkg::POS_MIN;
        else
            v = pos[vkq_pkg::POS_W-1:0];
    end

    // first sample after mute restarts the average
    assign restart = (avg_reg == vkq_pkg::MUTE_AVG);

    // avg + v - floor((avg - 8) / 16)
    assign avg_m8  = $signed({avg_reg[vkq_pkg::AVG_W-1], avg_reg})
                   - 13'(vkq_pkg::LEAK_BIAS);
    assign leak    = avg_m8 >>> vkq_pkg::LEAK_SHIFT;
    assign avg_sum = $signed({{(vkq_pkg::AVG_W + 2 - vkq_pkg::POS_W){v[vkq_pkg::POS_W-1]}}, v})
                   + $signed({{2{avg_reg[vkq_pkg::AVG_W-1]}}, avg_reg})
                   - $signed({leak[vkq_pkg::AVG_W], leak});
    assign avg_smooth = avg_sum[vkq_pkg::AVG_W-1:0];
    assign avg_div16  = avg_smooth[vkq_pkg::AVG_W-1:vkq_pkg::LEAK_SHIFT];

    always_comb
    begin
        if (avg_div16 > vkq_pkg::POS_MAX)
            smooth_pos = vkq_pkg::POS_MAX;
        else if (avg_div16 < vkq_pkg::POS_MIN)
            smooth_pos = vkq_pkg::POS_MIN;
        else
            smooth_pos = avg_div16[vkq_pkg::POS_W-1:0];
    end

    assign res_pos = restart ? v : smooth_pos;

    always_comb
    begin
        if (mute_reg)
        begin
            avg_next   = vkq_pkg::MUTE_AVG;
            level_next = vkq_pkg::MUTE_CODE;
        end
        else
        begin
            avg_next   = restart
                       ? $signed({{(vkq_pkg::AVG_W - vkq_pkg::POS_W - vkq_pkg::LEAK_SHIFT)
                                   {v[vkq_pkg::POS_W-1]}}, v, 4'b0000})
                       : avg_smooth;
            level_next = $signed({{(vkq_pkg::LEVEL_W - vkq_pkg::POS_W)
                                   {res_pos[vkq_pkg::POS_W-1]}}, res_pos});
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = mute_now ? ST_DONE : ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            latch_reg     <= 1'b0;
            avg_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                latch_reg     <= mute_reg;
                avg_reg       <= avg_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mute_reg <= mute_now;
            low_reg  <= low_seg;
            neg_reg  <= low_diff[vkq_pkg::THR_W];
        end
        if (finish)
        begin
            res_level_reg <= level_next;
            res_muted_reg <= mute_reg;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.volume_level = res_level_reg;
    assign result.muted        = res_muted_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_mute_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.muted |-> result.volume_level == vkq_pkg::MUTE_CODE)
        else $error("muted result without mute code");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.muted
            |-> result.volume_level <= 8'sd31 && result.volume_level >= -8'sd31)
        else $error("unmuted level out of range");

    a_mute_state: assert property (@(posedge clk) disable iff (!rst_n)
        finish && mute_reg |=> latch_reg && avg_reg == vkq_pkg::MUTE_AVG)
        else $error("mute did not latch or restart the average");

    a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

endmodule

`default_nettype wire
